// File: rtl/imd_pkg.sv
// Shared types and constants for the disk image stream parser.
package imd_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_COMMENT,
    PH_HEADER,
    PH_SMAP,
    PH_CMAP,
    PH_HMAP,
    PH_STYPE,
    PH_FILL,
    PH_DATA,
    PH_IGNORE,
    PH_DONE
  } imd_phase_t;

  localparam logic [7:0] EOC_MARK     = 8'h1A;
  localparam logic [7:0] RECORD_LIMIT = 8'd200;
  localparam int unsigned HEAD_CMAP_BIT = 7;
  localparam int unsigned HEAD_HMAP_BIT = 6;

  // Track header layout
  localparam logic [8:0] HEADER_LEN = 9'd5;
  localparam logic [7:0] HF_CYL     = 8'd1;
  localparam logic [7:0] HF_HEAD    = 8'd2;
  localparam logic [7:0] HF_COUNT   = 8'd3;

  // Sector type codes
  localparam logic [7:0] TYPE_ZERO = 8'd0;
  localparam logic [7:0] TYPE_LIT  = 8'd1;
  localparam logic [7:0] TYPE_FILL = 8'd2;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOMARK  = 3'd1;
  localparam logic [2:0] ST_TRUNC   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_SKIP    = 3'd4;
  localparam logic [2:0] ST_DROP    = 3'd5;

  // Command passed from the parser to the write stage
  typedef struct packed {
    logic       emit;     // sector write attempted on this word
    logic       trk_ok;   // cylinder in range
    logic [6:0] track;
    logic [7:0] num;      // sector number from the map
    logic [7:0] value;
    logic [7:0] run;
    logic [6:0] offset;
    logic       done;
    logic [2:0] status;   // status decided by the parser
    logic       trunc;    // image ended inside a record
  } imd_cmd_t;

  // Result word
  typedef struct packed {
    logic       write_valid;
    logic [6:0] track_number;
    logic [4:0] sector_index;
    logic [6:0] byte_offset;
    logic [7:0] data_value;
    logic [7:0] run_length;
    logic       sector_done;
    logic [2:0] status;
  } imd_res_t;

endpackage

// File: rtl/imd_stream_if.sv
// Valid/ready channel interfaces for image bytes and sector writes.
interface imd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;
  logic       last_byte;

  modport source (output valid, output image_byte, output last_byte, input ready);
  modport sink (input valid, input image_byte, input last_byte, output ready);
endinterface

interface imd_out_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [6:0] track_number;
  logic [4:0] sector_index;
  logic [6:0] byte_offset;
  logic [7:0] data_value;
  logic [7:0] run_length;
  logic       sector_done;
  logic [2:0] status;

  modport source (
    output valid, output write_valid, output track_number, output sector_index,
    output byte_offset, output data_value, output run_length, output sector_done,
    output status, input ready
  );
  modport sink (
    input valid, input write_valid, input track_number, input sector_index,
    input byte_offset, input data_value, input run_length, input sector_done,
    input status, output ready
  );
endinterface

// File: rtl/imd_front.sv
// Parser front end: phase FSM, counters and sector-number map memory.
module imd_front #(
  parameter int TRACK_COUNT  = 77,
  parameter int SECTOR_BYTES = 128,
  parameter int MAP_DEPTH    = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       image_byte,
  input  logic             last_byte,
  input  logic             cmd_full,
  output logic             cmd_push,
  output imd_pkg::imd_cmd_t cmd
);
  import imd_pkg::*;

  localparam int DCW = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;
  localparam int MIW = $clog2(MAP_DEPTH);
  localparam logic [DCW:0] SB_C   = (DCW+1)'(SECTOR_BYTES);
  localparam logic [10:0]  SB_W   = 11'(SECTOR_BYTES);
  localparam logic [7:0]   SB_RUN = SB_W[7:0];
  localparam logic [8:0]  TRK_LIM = 9'(TRACK_COUNT);
  localparam logic [8:0]  MAP_LIM = 9'(MAP_DEPTH);

  imd_phase_t phase_r, phase_nxt, phase_stp, after_maps, rec_phase;
  logic [7:0]     fc_r, fc_nxt;
  logic [7:0]     cyl_r, cyl_nxt;
  logic [1:0]     flags_r, flags_nxt;
  logic [7:0]     sit_r, sit_nxt;
  logic [7:0]     rec_r, rec_nxt;
  logic [DCW-1:0] dc_r, dc_nxt;
  logic [7:0]     ts_r, ts_nxt;

  logic           acc;
  logic [8:0]     fc_inc;
  logic [7:0]     rec_inc, ts_inc;
  logic [DCW:0]   dc_inc;
  logic [DCW+6:0] dc_ext;
  logic           hdr_end, map_end, sec_end, data_done, trk_ok;

  // map memory and its registered read port
  logic [7:0]     map_mem [MAP_DEPTH];
  logic           map_we;
  logic [7:0]     map_ra;
  logic [7:0]     map_rd_r, byp_d_r;
  logic           byp_r, rd_ok_r;
  logic [7:0]     num;

  logic           emit_c, done_c, trunc_c;
  logic [7:0]     val_c, run_c;
  logic [6:0]     off_c;
  logic [2:0]     st_c;

  assign in_ready = !cmd_full;
  assign acc      = in_valid && !cmd_full;
  assign cmd_push = acc;

  assign fc_inc    = {1'b0, fc_r} + 9'd1;
  assign rec_inc   = rec_r + 8'd1;
  assign ts_inc    = (ts_r != 8'hFF) ? ts_r + 8'd1 : ts_r;
  assign dc_inc    = {1'b0, dc_r} + {{DCW{1'b0}}, 1'b1};
  assign dc_ext    = {7'd0, dc_r};
  assign hdr_end   = fc_inc >= HEADER_LEN;
  assign map_end   = fc_inc >= {1'b0, sit_r};
  assign sec_end   = rec_inc >= sit_r;
  assign data_done = dc_inc >= SB_C;
  assign trk_ok    = {1'b0, cyl_r} < TRK_LIM;
  assign rec_phase = (ts_inc >= RECORD_LIMIT) ? PH_IGNORE : PH_HEADER;

  always_comb begin
    if (phase_r == PH_SMAP && flags_r[1]) begin
      after_maps = PH_CMAP;
    end else if (phase_r != PH_HMAP && flags_r[0]) begin
      after_maps = PH_HMAP;
    end else begin
      after_maps = PH_STYPE;
    end
  end

  // next state
  always_comb begin
    phase_stp = phase_r;
    fc_nxt    = fc_r;
    cyl_nxt   = cyl_r;
    flags_nxt = flags_r;
    sit_nxt   = sit_r;
    rec_nxt   = rec_r;
    dc_nxt    = dc_r;
    ts_nxt    = ts_r;
    case (phase_r)
      PH_COMMENT: begin
        if (image_byte == EOC_MARK) begin
          phase_stp = PH_HEADER;
          fc_nxt    = '0;
        end
      end
      PH_HEADER: begin
        case (fc_r)
          HF_CYL:   cyl_nxt = image_byte;
          HF_HEAD:  flags_nxt = {image_byte[HEAD_CMAP_BIT], image_byte[HEAD_HMAP_BIT]};
          HF_COUNT: sit_nxt = image_byte;
          default:  ;
        endcase
        fc_nxt = fc_inc[7:0];
        if (hdr_end) begin
          fc_nxt  = '0;
          rec_nxt = '0;
          if (sit_r == 8'd0) begin
            ts_nxt    = ts_inc;
            phase_stp = rec_phase;
          end else begin
            phase_stp = PH_SMAP;
          end
        end
      end
      PH_SMAP, PH_CMAP, PH_HMAP: begin
        fc_nxt = fc_inc[7:0];
        if (map_end) begin
          fc_nxt    = '0;
          phase_stp = after_maps;
        end
      end
      PH_STYPE: begin
        dc_nxt = '0;
        if (image_byte == TYPE_ZERO) begin
          rec_nxt = rec_inc;
          if (sec_end) begin
            ts_nxt    = ts_inc;
            fc_nxt    = '0;
            phase_stp = rec_phase;
          end else begin
            phase_stp = PH_STYPE;
          end
        end else if (image_byte == TYPE_FILL) begin
          phase_stp = PH_FILL;
        end else begin
          phase_stp = PH_DATA;
        end
      end
      PH_FILL: begin
        rec_nxt = rec_inc;
        if (sec_end) begin
          ts_nxt    = ts_inc;
          fc_nxt    = '0;
          phase_stp = rec_phase;
        end else begin
          phase_stp = PH_STYPE;
        end
      end
      PH_DATA: begin
        dc_nxt = dc_inc[DCW-1:0];
        if (data_done) begin
          rec_nxt = rec_inc;
          if (sec_end) begin
            ts_nxt    = ts_inc;
            fc_nxt    = '0;
            phase_stp = rec_phase;
          end else begin
            phase_stp = PH_STYPE;
          end
        end
      end
      default: ;
    endcase
    phase_nxt = phase_stp;
    if (last_byte && phase_stp != PH_DONE) begin
      phase_nxt = PH_DONE;
    end
  end

  // command word
  always_comb begin
    emit_c  = 1'b0;
    val_c   = '0;
    run_c   = '0;
    off_c   = '0;
    done_c  = 1'b0;
    st_c    = ST_OK;
    trunc_c = 1'b0;
    case (phase_r)
      PH_HEADER: begin
        if (hdr_end && sit_r != 8'd0 && !trk_ok) begin
          st_c = ST_SKIP;
        end
      end
      PH_STYPE: begin
        if (image_byte == TYPE_ZERO) begin
          emit_c = 1'b1;
          run_c  = SB_RUN;
          done_c = 1'b1;
        end else if (image_byte != TYPE_FILL && image_byte != TYPE_LIT) begin
          st_c = ST_UNKNOWN;
        end
      end
      PH_FILL: begin
        emit_c = 1'b1;
        val_c  = image_byte;
        run_c  = SB_RUN;
        done_c = 1'b1;
      end
      PH_DATA: begin
        emit_c = 1'b1;
        val_c  = image_byte;
        run_c  = 8'd1;
        off_c  = dc_ext[6:0];
        done_c = data_done;
      end
      default: ;
    endcase
    if (last_byte && phase_stp != PH_DONE) begin
      if (phase_stp == PH_COMMENT) begin
        st_c = ST_NOMARK;
      end else if (phase_stp != PH_IGNORE &&
                   !(phase_stp == PH_HEADER && fc_nxt == 8'd0)) begin
        trunc_c = 1'b1;
      end
    end
  end

  always_comb begin
    cmd.emit   = emit_c;
    cmd.trk_ok = trk_ok;
    cmd.track  = cyl_r[6:0];
    cmd.num    = num;
    cmd.value  = val_c;
    cmd.run    = run_c;
    cmd.offset = off_c;
    cmd.done   = done_c;
    cmd.status = st_c;
    cmd.trunc  = trunc_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COMMENT;
      fc_r    <= '0;
      cyl_r   <= '0;
      flags_r <= '0;
      sit_r   <= '0;
      rec_r   <= '0;
      dc_r    <= '0;
      ts_r    <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      cyl_r   <= cyl_nxt;
      flags_r <= flags_nxt;
      sit_r   <= sit_nxt;
      rec_r   <= rec_nxt;
      dc_r    <= dc_nxt;
      ts_r    <= ts_nxt;
    end
  end

  // Lookup always tracks the record index the next word will use;
  // a write to the same entry in that cycle is bypassed.
  assign map_we = acc && phase_r == PH_SMAP && {1'b0, fc_r} < MAP_LIM;
  assign map_ra = acc ? rec_nxt : rec_r;
  assign num    = !rd_ok_r ? 8'd0 : (byp_r ? byp_d_r : map_rd_r);

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[fc_r[MIW-1:0]] <= image_byte;
    end
    map_rd_r <= map_mem[map_ra[MIW-1:0]];
    byp_r    <= map_we && fc_r[MIW-1:0] == map_ra[MIW-1:0];
    byp_d_r  <= image_byte;
    rd_ok_r  <= {1'b0, map_ra} < MAP_LIM;
  end

`ifndef NO_ASSERTIONS
  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("parser left the done phase");
  a_record_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ts_r >= RECORD_LIMIT |-> (phase_r == PH_IGNORE || phase_r == PH_DONE))
    else $error("parsing continued past the record limit");
`endif

endmodule

// File: rtl/imd_cmd_fifo.sv
// Two-word command queue between the parser and the write stage.
module imd_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  imd_pkg::imd_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output imd_pkg::imd_cmd_t pop_data
);
  import imd_pkg::*;

  imd_cmd_t   buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3 && (cnt_r == 2'd1) == (wp_r != rp_r))
    else $error("queue count and pointers disagree");
`endif

endmodule

// File: rtl/imd_back.sv
// Write stage: sector range check, status merge and output register.
module imd_back #(
  parameter int SECTORS_PER_TRACK = 26
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  imd_pkg::imd_cmd_t cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output imd_pkg::imd_res_t res
);
  import imd_pkg::*;

  localparam logic [8:0] SPT_LIM = 9'(SECTORS_PER_TRACK);

  logic     out_valid_r;
  imd_res_t res_r, res_nxt;
  logic     sec_ok, wr;
  logic [7:0] num_m1;

  assign cmd_pop   = cmd_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  assign sec_ok = cmd.num != 8'd0 && {1'b0, cmd.num} <= SPT_LIM;
  assign wr     = cmd.emit && cmd.trk_ok && sec_ok;
  assign num_m1 = cmd.num - 8'd1;

  always_comb begin
    res_nxt = '0;
    if (wr) begin
      res_nxt.write_valid  = 1'b1;
      res_nxt.track_number = cmd.track;
      res_nxt.sector_index = num_m1[4:0];
      res_nxt.byte_offset  = cmd.offset;
      res_nxt.data_value   = cmd.value;
      res_nxt.run_length   = cmd.run;
      res_nxt.sector_done  = cmd.done;
    end
    if (cmd.trunc) begin
      res_nxt.status = ST_TRUNC;
    end else if (cmd.emit) begin
      // dropped sector reported only when its last byte goes by
      res_nxt.status = (!wr && cmd.trk_ok && cmd.done) ? ST_DROP : ST_OK;
    end else begin
      res_nxt.status = cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.write_valid |-> (res_r.status == ST_OK || res_r.status == ST_TRUNC))
    else $error("write issued with an error status");
`endif

endmodule

// File: rtl/imd_disk_image_stream_parser_unit.sv
// Top level of the disk image stream parser: parser, command queue, write stage.
//
//  channel  | dir | payload                                             | accept
//  ---------+-----+-----------------------------------------------------+-------------
//  in_if    | in  | image_byte, last_byte                               | valid & ready
//  out_if   | out | write_valid, track_number, sector_index, byte_offset,| valid & ready
//           |     | data_value, run_length, sector_done, status         |
//
// One byte per cycle sustained while out_if is not stalled; each word gives exactly one result word.
// Each taken byte goes from its parse step into the two-word queue, then into the output register.
// The sector-number map is a MAP_DEPTH x 8 memory with a registered read; the
// lookup for the next sector is issued in the cycle the current word is taken.
// Reset is synchronous, active low; the map memory is not cleared.
// A stalled output fills the queue, after which in_if.ready drops.
module imd_disk_image_stream_parser_unit #(
  parameter int TRACK_COUNT       = 77,
  parameter int SECTORS_PER_TRACK = 26,
  parameter int SECTOR_BYTES      = 128,
  parameter int MAP_DEPTH         = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  imd_in_if.sink           in_if,
  imd_out_if.source        out_if
);
  import imd_pkg::*;

  imd_cmd_t push_cmd, pop_cmd;
  imd_res_t res;
  logic     push, pop, full, empty;

  imd_front #(
    .TRACK_COUNT  (TRACK_COUNT),
    .SECTOR_BYTES (SECTOR_BYTES),
    .MAP_DEPTH    (MAP_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .image_byte (in_if.image_byte),
    .last_byte  (in_if.last_byte),
    .cmd_full   (full),
    .cmd_push   (push),
    .cmd        (push_cmd)
  );

  imd_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (pop_cmd)
  );

  imd_back #(
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!empty),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .res       (res)
  );

  assign out_if.write_valid  = res.write_valid;
  assign out_if.track_number = res.track_number;
  assign out_if.sector_index = res.sector_index;
  assign out_if.byte_offset  = res.byte_offset;
  assign out_if.data_value   = res.data_value;
  assign out_if.run_length   = res.run_length;
  assign out_if.sector_done  = res.sector_done;
  assign out_if.status       = res.status;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the disk image stream parser unit.
`timescale 1ns / 1ps

module tb;
  import imd_pkg::*;

  localparam int NUM_TRACKS   = 77;
  localparam int SECTORS      = 26;
  localparam int SECTOR_BYTES = 128;
  localparam int MAP_DEPTH    = 256;
  localparam int INTRO_ROWS   = 26;
  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 5000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int SHOW_LIMIT   = 10;
  localparam logic [7:0] SECTOR_RUN = 8'(SECTOR_BYTES);

  // zero-type sector on the last track, sector number 26
  localparam imd_res_t ZERO_S26 = '{1'b1, 7'd76, 5'd25, 7'd0, 8'h00, 8'd128, 1'b1, ST_OK};

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         fixed;
    imd_res_t   want;
  } image_row_t;

  logic clk;
  logic rst_n;

  imd_in_if  in_bus ();
  imd_out_if out_bus ();

  imd_disk_image_stream_parser_unit #(
    .TRACK_COUNT      (NUM_TRACKS),
    .SECTORS_PER_TRACK(SECTORS),
    .SECTOR_BYTES     (SECTOR_BYTES),
    .MAP_DEPTH        (MAP_DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .out_if(out_bus)
  );

  always #2 clk = ~clk;

  // stimulus and expected words
  image_row_t  stim_q[$];
  image_row_t  intro_rows[INTRO_ROWS];
  image_row_t  cur_row;
  logic [7:0]  rec_bytes[$];
  imd_res_t    due_writes[$];
  int unsigned bytes_taken;
  int unsigned fail_count;
  int unsigned cycles;

  // parser copy
  imd_phase_t  p_phase;
  logic [7:0]  p_field;
  logic [7:0]  p_cyl;
  logic [1:0]  p_maps;
  logic [7:0]  p_nsec;
  logic [7:0]  p_rec;
  int unsigned p_data;
  logic [7:0]  p_smap[MAP_DEPTH];
  logic [7:0]  p_tracks;
  imd_res_t    p_word;

  function automatic void clear_parser();
    p_phase  = PH_COMMENT;
    p_field  = '0;
    p_cyl    = '0;
    p_maps   = '0;
    p_nsec   = '0;
    p_rec    = '0;
    p_data   = 0;
    p_tracks = '0;
    for (int i = 0; i < MAP_DEPTH; i++) p_smap[i] = '0;
  endfunction

  function automatic void close_record();
    if (p_tracks < 8'd255) p_tracks++;
    p_field = '0;
    p_phase = (p_tracks >= RECORD_LIMIT) ? PH_IGNORE : PH_HEADER;
  endfunction

  function automatic void close_sector();
    p_rec++;
    if (p_rec >= p_nsec) close_record();
    else p_phase = PH_STYPE;
  endfunction

  function automatic imd_phase_t next_map(imd_phase_t from);
    if (from == PH_SMAP && p_maps[1]) return PH_CMAP;
    if (from != PH_HMAP && p_maps[0]) return PH_HMAP;
    return PH_STYPE;
  endfunction

  // fills p_word when the sector is writable, else returns a drop status on a sector's last byte in range
  function automatic logic [2:0] store_write(logic [7:0] value, logic [7:0] run,
                                             logic [6:0] offset, logic done);
    logic [7:0] num;
    logic       trk_ok;
    num    = p_smap[p_rec];
    trk_ok = p_cyl < NUM_TRACKS;
    if (trk_ok && num >= 1 && num <= SECTORS) begin
      p_word.write_valid  = 1'b1;
      p_word.track_number = p_cyl[6:0];
      p_word.sector_index = 5'(num - 8'd1);
      p_word.byte_offset  = offset;
      p_word.data_value   = value;
      p_word.run_length   = run;
      p_word.sector_done  = done;
      return ST_OK;
    end
    return (trk_ok && done) ? ST_DROP : ST_OK;
  endfunction

  function automatic imd_res_t decode_byte(logic [7:0] b, logic last);
    logic [2:0] st;
    logic       fin;
    st     = ST_OK;
    p_word = '0;
    case (p_phase)
      PH_COMMENT: begin
        if (b == EOC_MARK) begin
          p_phase = PH_HEADER;
          p_field = '0;
        end
      end
      PH_HEADER: begin
        if (p_field == HF_CYL) p_cyl = b;
        else if (p_field == HF_HEAD) p_maps = {b[HEAD_CMAP_BIT], b[HEAD_HMAP_BIT]};
        else if (p_field == HF_COUNT) p_nsec = b;
        p_field++;
        if (p_field >= HEADER_LEN) begin
          p_field = '0;
          p_rec   = '0;
          if (p_nsec == 0) begin
            close_record();
          end else begin
            if (p_cyl >= NUM_TRACKS) st = ST_SKIP;
            p_phase = PH_SMAP;
          end
        end
      end
      PH_SMAP, PH_CMAP, PH_HMAP: begin
        if (p_phase == PH_SMAP) p_smap[p_field] = b;
        p_field++;
        if (p_field >= p_nsec) begin
          p_field = '0;
          p_phase = next_map(p_phase);
        end
      end
      PH_STYPE: begin
        p_data = 0;
        if (b == TYPE_ZERO) begin
          st = store_write(8'h00, SECTOR_RUN, 7'd0, 1'b1);
          close_sector();
        end else if (b == TYPE_FILL) begin
          p_phase = PH_FILL;
        end else begin
          if (b != TYPE_LIT) st = ST_UNKNOWN;
          p_phase = PH_DATA;
        end
      end
      PH_FILL: begin
        st = store_write(b, SECTOR_RUN, 7'd0, 1'b1);
        close_sector();
      end
      PH_DATA: begin
        fin = (p_data + 1 >= SECTOR_BYTES);
        st  = store_write(b, 8'd1, 7'(p_data), fin);
        p_data++;
        if (fin) close_sector();
      end
      default: ;
    endcase
    if (last && p_phase != PH_DONE) begin
      if (p_phase == PH_COMMENT) st = ST_NOMARK;
      else if (p_phase != PH_IGNORE && !(p_phase == PH_HEADER && p_field == 0)) st = ST_TRUNC;
      p_phase = PH_DONE;
    end
    p_word.status = st;
    return p_word;
  endfunction

  function automatic imd_res_t status_only(logic [2:0] st);
    imd_res_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  function automatic image_row_t step_row(logic [7:0] b, bit fixed = 1'b0,
                                          imd_res_t want = '0);
    image_row_t r;
    r = '{b, 1'b0, fixed, want};
    return r;
  endfunction

  function automatic void add_byte(logic [7:0] b, logic last);
    image_row_t r;
    r      = step_row(b);
    r.last = last;
    stim_q.push_back(r);
  endfunction

  // one random track record into rec_bytes; mostly well formed, some bad numbers
  function automatic void build_record();
    int unsigned n;
    int unsigned kind;
    logic [7:0]  head;
    rec_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) n = 0;
    else if (kind < 12) n = $urandom_range(27, 40);
    else if (kind < 30) n = $urandom_range(7, SECTORS);
    else n = $urandom_range(1, 6);
    head = 8'($urandom);
    rec_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 7) == 0) rec_bytes.push_back(8'($urandom_range(NUM_TRACKS, 255)));
    else rec_bytes.push_back(8'($urandom_range(0, NUM_TRACKS - 1)));
    rec_bytes.push_back(head);
    rec_bytes.push_back(8'(n));
    rec_bytes.push_back(8'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) rec_bytes.push_back(8'($urandom));
      else rec_bytes.push_back(8'($urandom_range(1, SECTORS)));
    end
    if (head[HEAD_CMAP_BIT]) for (int i = 0; i < n; i++) rec_bytes.push_back(8'($urandom));
    if (head[HEAD_HMAP_BIT]) for (int i = 0; i < n; i++) rec_bytes.push_back(8'($urandom));
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 47) begin
        rec_bytes.push_back(TYPE_ZERO);
      end else if (kind < 94 || n > SECTORS) begin
        rec_bytes.push_back(TYPE_FILL);
        rec_bytes.push_back(8'($urandom));
      end else begin
        rec_bytes.push_back(kind < 97 ? TYPE_LIT : 8'($urandom_range(3, 255)));
        for (int j = 0; j < SECTOR_BYTES; j++) rec_bytes.push_back(8'($urandom));
      end
    end
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit same_word(imd_res_t a, imd_res_t b);
    return a.write_valid  === b.write_valid  && a.track_number === b.track_number &&
           a.sector_index === b.sector_index && a.byte_offset  === b.byte_offset  &&
           a.data_value   === b.data_value   && a.run_length   === b.run_length   &&
           a.sector_done  === b.sector_done  && a.status       === b.status;
  endfunction

  task automatic log_mismatch(string what, imd_res_t want, imd_res_t got);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) begin
      $display("%0t %s exp: wv=%0d trk=%0d sec=%0d off=%0d val=%02h run=%0d done=%0d st=%0d",
               $realtime, what, want.write_valid, want.track_number, want.sector_index,
               want.byte_offset, want.data_value, want.run_length, want.sector_done,
               want.status);
      $display("%0t %s got: wv=%0d trk=%0d sec=%0d off=%0d val=%02h run=%0d done=%0d st=%0d",
               $realtime, what, got.write_valid, got.track_number, got.sector_index,
               got.byte_offset, got.data_value, got.run_length, got.sector_done, got.status);
    end
  endtask

  // byte source
  int unsigned next_row;
  int unsigned src_gap;
  int unsigned src_steady;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      next_row     <= 0;
      src_gap      <= 0;
      src_steady   <= 0;
    end else begin
      if (src_steady != 0) src_steady <= src_steady - 1;
      else if ($urandom_range(0, 99) == 0) src_steady <= $urandom_range(40, 200);
      if (!in_bus.valid || in_bus.ready) begin
        if (src_gap != 0) begin
          in_bus.valid <= 1'b0;
          src_gap      <= src_gap - 1;
        end else if (next_row < stim_q.size()) begin
          in_bus.valid      <= 1'b1;
          in_bus.image_byte <= stim_q[next_row].b;
          in_bus.last_byte  <= stim_q[next_row].last;
          cur_row           <= stim_q[next_row];
          next_row          <= next_row + 1;
          src_gap           <= (src_steady != 0) ? 0 : pick_idle();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result sink backpressure
  int unsigned sink_hold;
  int unsigned sink_steady;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      sink_hold     <= 0;
      sink_steady   <= 0;
    end else begin
      if (sink_steady != 0) sink_steady <= sink_steady - 1;
      else if ($urandom_range(0, 99) == 0) sink_steady <= $urandom_range(40, 200);
      if (sink_hold != 0) begin
        out_bus.ready <= 1'b0;
        sink_hold     <= sink_hold - 1;
      end else begin
        out_bus.ready <= 1'b1;
        sink_hold     <= (sink_steady != 0) ? 0 : pick_idle();
      end
    end
  end

  // check the result word first, then queue the prediction for a taken byte
  imd_res_t seen_word;
  imd_res_t due_word;
  imd_res_t model_word;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        seen_word = '{out_bus.write_valid, out_bus.track_number, out_bus.sector_index,
                      out_bus.byte_offset, out_bus.data_value, out_bus.run_length,
                      out_bus.sector_done, out_bus.status};
        if (due_writes.size() == 0) begin
          log_mismatch("unexpected word", '0, seen_word);
        end else begin
          due_word = due_writes.pop_front();
          if (!same_word(due_word, seen_word)) log_mismatch("word mismatch", due_word, seen_word);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        model_word = decode_byte(in_bus.image_byte, in_bus.last_byte);
        due_writes.push_back(cur_row.fixed ? cur_row.want : model_word);
        bytes_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned records;
    int unsigned cut;
    bit          to_limit;
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.image_byte = '0;
    in_bus.last_byte  = 1'b0;
    out_bus.ready     = 1'b0;
    bytes_taken       = 0;
    fail_count        = 0;
    cycles            = 0;
    clear_parser();

    intro_rows = '{
      // comment, then marker
      step_row(8'h00, 1'b1, status_only(ST_OK)),
      step_row(EOC_MARK, 1'b1, status_only(ST_OK)),
      // record with no sectors
      step_row(8'h00), step_row(8'h00), step_row(8'h00), step_row(8'h00), step_row(8'hFF),
      // first out-of-range cylinder, both extra maps, one sector
      step_row(8'hFF), step_row(8'h4D), step_row(8'hC0), step_row(8'h01),
      step_row(8'h00, 1'b1, status_only(ST_SKIP)),
      step_row(8'h05), step_row(8'hAA), step_row(8'h55),
      step_row(TYPE_ZERO, 1'b1, status_only(ST_OK)),
      // last cylinder, no maps: sector 26 zeroed, sector number 0 filled and dropped
      step_row(8'h02), step_row(8'h4C), step_row(8'h3F), step_row(8'h02), step_row(8'h07),
      step_row(8'h1A), step_row(8'h00),
      step_row(TYPE_ZERO, 1'b1, ZERO_S26),
      step_row(TYPE_FILL),
      step_row(8'hFF, 1'b1, status_only(ST_DROP))
    };
    for (int i = 0; i < INTRO_ROWS; i++) stim_q.push_back(intro_rows[i]);
    records = 3;

    // the record-limit run is long on its own, so it gets no random records
    to_limit = ($urandom_range(0, 3) == 0);

    while (!to_limit && stim_q.size() < RANDOM_ITEMS && records < RECORD_LIMIT - 10) begin
      build_record();
      foreach (rec_bytes[i]) add_byte(rec_bytes[i], 1'b0);
      records++;
    end

    if (to_limit) begin
      // run up to the record limit with empty records; later bytes are ignored
      while (records < RECORD_LIMIT) begin
        add_byte(8'($urandom), 1'b0);
        add_byte(8'($urandom), 1'b0);
        add_byte(8'($urandom), 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'($urandom), 1'b0);
        records++;
      end
      cut = $urandom_range(2, 8);
      for (int i = 0; i < cut; i++) add_byte(8'($urandom), i == cut - 1);
    end else begin
      // image ends inside a record
      build_record();
      cut = $urandom_range(0, rec_bytes.size() - 2);
      for (int i = 0; i <= cut; i++) add_byte(rec_bytes[i], i == cut);
    end
    // bytes after the end of the image
    cut = $urandom_range(1, 4);
    for (int i = 0; i < cut; i++) add_byte(8'($urandom), 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < stim_q.size()) @(posedge clk);
    while (due_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
